FILE: src/cvst_pkg.sv
// ----------------------------------------------------------------------------
// cvst_pkg
// Shared sizes, codes and controller/datapath signal groups of the value set
// table.
// ----------------------------------------------------------------------------
package cvst_pkg;

  // table geometry
  localparam int DEPTH    = 128;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 7;

  // empty slot marker (all ones, -1)
  localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic clear_wr;
    logic load;
    logic scan_rd;
    logic wr_hit;
    logic wr_last;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic cnt_last;
    logic issue_done;
    logic rd_pend;
    logic found;
    logic used;
    logic early;
    logic is_insert;
    logic is_delete;
  } stat_t;

endpackage

FILE: src/cvst_req_if.sv
// ----------------------------------------------------------------------------
// cvst_req_if
// Request channel: one table operation with its value.
// ----------------------------------------------------------------------------
interface cvst_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [cvst_pkg::KIND_W-1:0]          kind;
  logic signed [cvst_pkg::DATA_W-1:0]   item_value;

  modport source (output valid, output kind, output item_value, input ready);
  modport sink   (input valid, input kind, input item_value, output ready);
endinterface

FILE: src/cvst_rsp_if.sv
// ----------------------------------------------------------------------------
// cvst_rsp_if
// Response channel: status and slot of one finished request.
// ----------------------------------------------------------------------------
interface cvst_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [cvst_pkg::STATUS_W-1:0]     status;
  logic [cvst_pkg::SLOT_W-1:0]       slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

FILE: src/cvst_ctrl.sv
// ----------------------------------------------------------------------------
// cvst_ctrl
// Sequencer of the value set table: clearing pass, table scan, write back
// and response hand-off.
// ----------------------------------------------------------------------------
module cvst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output cvst_pkg::cmd_t   cmd,
  input  cvst_pkg::stat_t  stat
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WR_HIT,
    S_WR_LAST,
    S_FINISH
  } state_t;

  state_t state;
  logic   scan_end;

  // scan ends, no read in flight, after the last slot or an early hit
  assign scan_end = !stat.rd_pend && (stat.issue_done || (stat.found && stat.early));

  // command decode
  always_comb begin
    cmd      = '0;
    in_ready = (state == S_IDLE);
    case (state)
      S_CLEAR:   cmd.clear_wr = 1'b1;
      S_IDLE:    cmd.load     = in_valid;
      S_SCAN:    cmd.scan_rd  = !stat.issue_done && !(stat.found && stat.early);
      S_WR_HIT:  cmd.wr_hit   = 1'b1;
      S_WR_LAST: cmd.wr_last  = 1'b1;
      S_FINISH:  cmd.out_load = !out_valid || out_ready;
      default:   cmd          = '0;
    endcase
  end

  // state and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (stat.cnt_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_end) begin
            if (stat.found && stat.is_insert) begin
              state <= S_WR_HIT;
            end else if (stat.found && stat.is_delete && stat.used) begin
              state <= S_WR_HIT;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_WR_HIT: begin
          state <= stat.is_delete ? S_WR_LAST : S_FINISH;
        end
        S_WR_LAST: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (cmd.out_load) state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

FILE: src/cvst_dpath.sv
// ----------------------------------------------------------------------------
// cvst_dpath
// Datapath of the value set table: entry memory, scan counter, match and
// last-occupied trackers, and the response register.
// ----------------------------------------------------------------------------
module cvst_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  cvst_pkg::cmd_t                      cmd,
  output cvst_pkg::stat_t                     stat,
  input  logic [cvst_pkg::KIND_W-1:0]         in_kind,
  input  logic [cvst_pkg::DATA_W-1:0]         in_value,
  output logic [cvst_pkg::STATUS_W-1:0]       out_status,
  output logic [cvst_pkg::SLOT_W-1:0]         out_slot
);

  logic [cvst_pkg::DATA_W-1:0]   mem [cvst_pkg::DEPTH];

  logic [cvst_pkg::KIND_W-1:0]   req_kind;
  logic [cvst_pkg::DATA_W-1:0]   req_value;
  logic [cvst_pkg::DATA_W-1:0]   target;
  logic [cvst_pkg::IDX_W-1:0]    cnt;
  logic                          issue_done;
  logic                          rd_pend;
  logic [cvst_pkg::IDX_W-1:0]    rd_idx;
  logic [cvst_pkg::DATA_W-1:0]   rd_data;
  logic                          found;
  logic [cvst_pkg::IDX_W-1:0]    hit;
  logic                          used;
  logic [cvst_pkg::IDX_W-1:0]    last;
  logic [cvst_pkg::DATA_W-1:0]   last_value;
  logic                          cnt_last;
  logic                          is_match;
  logic                          is_used;

  logic                          wr_en;
  logic [cvst_pkg::IDX_W-1:0]    wr_addr;
  logic [cvst_pkg::DATA_W-1:0]   wr_data;
  logic [cvst_pkg::STATUS_W-1:0] status_next;
  logic [cvst_pkg::SLOT_W-1:0]   slot_next;

  assign cnt_last = (cnt == cvst_pkg::IDX_W'(cvst_pkg::DEPTH - 1));
  assign is_match = (rd_data == target);
  assign is_used  = (rd_data != cvst_pkg::EMPTY_WORD);

  // status toward the controller
  always_comb begin
    stat.cnt_last   = cnt_last;
    stat.issue_done = issue_done;
    stat.rd_pend    = rd_pend;
    stat.found      = found;
    stat.used       = used;
    stat.early      = (req_kind != cvst_pkg::KIND_DELETE);
    stat.is_insert  = (req_kind == cvst_pkg::KIND_INSERT);
    stat.is_delete  = (req_kind == cvst_pkg::KIND_DELETE);
  end

  // single write port: clearing pass, write at match, empty the last slot
  always_comb begin
    wr_en   = cmd.clear_wr || cmd.wr_hit || cmd.wr_last;
    wr_addr = cnt;
    wr_data = cvst_pkg::EMPTY_WORD;
    if (cmd.wr_hit) begin
      wr_addr = hit;
      wr_data = (req_kind == cvst_pkg::KIND_INSERT) ? req_value : last_value;
    end else if (cmd.wr_last) begin
      wr_addr = last;
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.scan_rd) begin
      rd_data <= mem[cnt];
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      issue_done <= 1'b0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      used       <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_rd;
      if (cmd.load) begin
        cnt        <= '0;
        issue_done <= 1'b0;
        found      <= 1'b0;
        used       <= 1'b0;
      end else begin
        if (cmd.clear_wr || cmd.scan_rd) begin
          cnt <= cnt + 1'b1;
        end
        if (cmd.scan_rd && cnt_last) begin
          issue_done <= 1'b1;
        end
        if (rd_pend && !found && is_match) begin
          found <= 1'b1;
        end
        if (rd_pend && is_used) begin
          used <= 1'b1;
        end
      end
    end
  end

  // request capture and tracker payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind  <= in_kind;
      req_value <= in_value;
      target    <= (in_kind == cvst_pkg::KIND_INSERT) ? cvst_pkg::EMPTY_WORD : in_value;
    end
    if (cmd.scan_rd) begin
      rd_idx <= cnt;
    end
    if (rd_pend && !found && is_match) begin
      hit <= rd_idx;
    end
    if (rd_pend && is_used) begin
      last       <= rd_idx;
      last_value <= rd_data;
    end
  end

  // response value
  always_comb begin
    status_next = cvst_pkg::ST_MISS;
    slot_next   = '0;
    case (req_kind)
      cvst_pkg::KIND_INSERT: begin
        status_next = found ? cvst_pkg::ST_OK : cvst_pkg::ST_FULL;
        slot_next   = found ? cvst_pkg::SLOT_W'(hit) : '0;
      end
      cvst_pkg::KIND_SEARCH, cvst_pkg::KIND_DELETE: begin
        status_next = found ? cvst_pkg::ST_OK : cvst_pkg::ST_MISS;
        slot_next   = found ? cvst_pkg::SLOT_W'(hit) : '0;
      end
      default: begin
        status_next = cvst_pkg::ST_MISS;
        slot_next   = '0;
      end
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= status_next;
      out_slot   <= slot_next;
    end
  end

endmodule

FILE: src/compact_value_set_table_unit.sv
// ----------------------------------------------------------------------------
// compact_value_set_table_unit
// Table of signed 32-bit values with -1 as the empty marker; insert, search
// and delete with move of the highest occupied entry into the freed slot.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over all DEPTH slots (128) that writes
// the empty marker into every slot; no request is taken until it ends. Each
// request is then served by reading the entry memory one slot per cycle
// through its single registered read port: insert and search stop at the
// first slot that matches, and an insert then writes its value into that
// slot; delete always scans all DEPTH slots to find the highest occupied
// entry and, when the value was found, moves that entry into the freed slot
// and empties its old slot. One request is handled at a time; a finished
// response sits in an output register, so the next request is accepted
// while it waits.
module compact_value_set_table_unit (
  input  logic          clk,
  input  logic          rst,
  cvst_req_if.sink      req,
  cvst_rsp_if.source    rsp
);

  cvst_pkg::cmd_t  cmd;
  cvst_pkg::stat_t stat;

  // sequencer
  cvst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  // memory and trackers
  cvst_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (req.kind),
    .in_value   (req.item_value),
    .out_status (rsp.status),
    .out_slot   (rsp.slot_index)
  );

endmodule
